### src/ellipse_ring_pixel_coverage_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ellipse and ring pixel coverage block
// Each macro clocks on i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_RING_PIXEL_COVERAGE_MACROS_SVH
`define ELLIPSE_RING_PIXEL_COVERAGE_MACROS_SVH

// Same-cycle implication.
`define ERPC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after the delay given by dly.
`define ERPC_ASSERT_DLY(name, ante, dly, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

### src/erpc_pkg.sv
// ----------------------------------------------------------------------------
// erpc_pkg
// Shared widths, register codes and lane types of the pixel coverage block.
// ----------------------------------------------------------------------------
`default_nettype none

package erpc_pkg;

    localparam int POS_W      = 24;  // pixel centre coordinate
    localparam int LEN_W      = 23;  // axes, radii, pixel size
    localparam int SINE_W     = 17;  // ring sine, Q1.16
    localparam int SINE_FRAC  = 16;
    localparam int COV_W      = 18;  // coverage result
    localparam int AX_W       = 25;  // doubled axis
    localparam int OFF_W      = 27;  // doubled edge offset, signed
    localparam int DIV_W      = 24;  // doubled pixel size
    localparam int T_W        = 48;  // radicand
    localparam int SQ_BITS    = 24;  // square root result bits
    localparam int DIV1_QBITS = 25;  // quotient bits of the chord scaling
    localparam int N_W        = 25;  // crossing numerator when in range

    localparam logic [LEN_W-1:0]  PIXEL_SIZE_RST = 23'd65536;
    localparam logic [SINE_W-1:0] RING_SINE_RST  = 17'd65536;
    localparam logic [SINE_W-1:0] SINE_ONE       = 17'd65536;

    typedef enum logic [1:0] {
        REG_PIXEL_SIZE = 2'd0,
        REG_RING_SINE  = 2'd1
    } t_reg_idx;

    // Operands of one edge crossing lane.
    typedef struct packed {
        logic [AX_W-1:0]         num;
        logic [AX_W-1:0]         den;
        logic signed [OFF_W-1:0] off2;
        logic signed [OFF_W-1:0] near2;
        logic [DIV_W-1:0]        div;
    } t_edge_in;

    // Values carried alongside the root and quotient chains.
    typedef struct packed {
        logic [AX_W-1:0]         num;
        logic [AX_W-1:0]         den;
        logic signed [OFF_W-1:0] near2;
        logic [DIV_W-1:0]        div;
        logic                    neg;
    } t_carry;

    // Cycles from lane operand register to lane result register.
    function automatic int erpc_edge_lat(input int frac);
        return 55 + frac;
    endfunction

    function automatic logic [LEN_W-1:0] erpc_min1(input logic [LEN_W-1:0] v);
        return (v == '0) ? LEN_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

### src/ellipse_ring_pixel_coverage.sv
// ----------------------------------------------------------------------------
// ellipse_ring_pixel_coverage
// Fraction of a square pixel inside a centred ellipse, or inside a ring.
// ----------------------------------------------------------------------------
// A transaction is taken at every rising edge with i_start high; o_busy never
// rises, so a new pixel may be offered in every cycle. Each transaction gives
// exactly one result, shown on o_coverage and o_fault with o_valid high for a
// single cycle, in order. The receiver cannot hold a result off, so take it
// when o_valid is high. Each of the eight crossing lanes runs a 24-stage
// square root, a 25-stage divider and a (FRAC_BITS + 1)-stage divider in
// series. Write pixel_size and ring_sine only while no transaction is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ellipse_ring_pixel_coverage_macros.svh"

module ellipse_ring_pixel_coverage
    import erpc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic                    i_action,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic [LEN_W-1:0]        i_major_axis,
    input  logic [LEN_W-1:0]        i_minor_axis,
    input  logic [LEN_W-1:0]        i_inner_radius,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [LEN_W-1:0]        i_cfg_data,
    output logic                    o_valid,
    output logic signed [COV_W-1:0] o_coverage,
    output logic                    o_fault
);

    localparam int EDGE_LAT = erpc_edge_lat(FRAC_BITS);
    localparam int LATENCY  = EDGE_LAT + 6;
    localparam int CW       = FRAC_BITS + 3;
    localparam int UW       = FRAC_BITS + 1;
    localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
    localparam logic [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;

    // Fully pipelined: nothing ever holds the input off.
    assign o_busy = 1'b0;

    // Configuration registers.
    logic [LEN_W-1:0]  r_pixel_size;
    logic [SINE_W-1:0] r_ring_sine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_size <= PIXEL_SIZE_RST;
            r_ring_sine  <= RING_SINE_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PIXEL_SIZE: r_pixel_size <= i_cfg_data;
                REG_RING_SINE:  r_ring_sine  <= i_cfg_data[SINE_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 0: fold the centre into the first quadrant, clamp the registers.
    logic [POS_W-1:0]  n_ax, n_ay;
    logic              r0_valid, r0_action;
    logic [POS_W-1:0]  r0_ax, r0_ay;
    logic [LEN_W-1:0]  r0_major, r0_minor, r0_inner, r0_res;
    logic [SINE_W-1:0] r0_sine;

    assign n_ax = i_pos_x[POS_W-1] ? POS_W'(-i_pos_x) : POS_W'(i_pos_x);
    assign n_ay = i_pos_y[POS_W-1] ? POS_W'(-i_pos_y) : POS_W'(i_pos_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= i_start && !o_busy;
        end
        r0_action <= i_action;
        r0_ax     <= n_ax;
        r0_ay     <= n_ay;
        r0_major  <= i_major_axis;
        r0_minor  <= i_minor_axis;
        r0_inner  <= i_inner_radius;
        r0_res    <= erpc_min1(r_pixel_size);
        r0_sine   <= (r_ring_sine > SINE_ONE) ? SINE_ONE : r_ring_sine;
    end

    // Stage 1: ring minor axes, then pick the two ellipses' axes.
    logic [LEN_W+SINE_W-1:0] n_po, n_pi;
    logic                    r1_valid, r1_action;
    logic [POS_W-1:0]        r1_ax, r1_ay;
    logic [LEN_W-1:0]        r1_res, r1_a0, r1_b0, r1_a1, r1_b1;

    assign n_po = (LEN_W+SINE_W)'(r0_major) * (LEN_W+SINE_W)'(r0_sine);
    assign n_pi = (LEN_W+SINE_W)'(r0_inner) * (LEN_W+SINE_W)'(r0_sine);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r0_valid;
        end
        r1_action <= r0_action;
        r1_ax     <= r0_ax;
        r1_ay     <= r0_ay;
        r1_res    <= r0_res;
        r1_a0     <= erpc_min1(r0_major);
        r1_b0     <= r0_action ? erpc_min1(n_po[SINE_FRAC +: LEN_W]) : erpc_min1(r0_minor);
        r1_a1     <= erpc_min1(r0_inner);
        r1_b1     <= erpc_min1(n_pi[SINE_FRAC +: LEN_W]);
    end

    // Stage 2: doubled lengths for the eight lanes. Lane order per ellipse:
    // bottom edge, top edge, left edge, right edge.
    logic signed [OFF_W-1:0] n_xm, n_xp, n_ym, n_yp;
    logic [AX_W-1:0]         n_a [0:1];
    logic [AX_W-1:0]         n_b [0:1];
    logic [DIV_W-1:0]        n_div;
    t_edge_in                n_op [0:7];
    t_edge_in                r2_op [0:7];
    logic                    r2_valid, r2_action;

    assign n_xm  = $signed({2'b0, r1_ax, 1'b0}) - $signed({4'b0, r1_res});
    assign n_xp  = $signed({2'b0, r1_ax, 1'b0}) + $signed({4'b0, r1_res});
    assign n_ym  = $signed({2'b0, r1_ay, 1'b0}) - $signed({4'b0, r1_res});
    assign n_yp  = $signed({2'b0, r1_ay, 1'b0}) + $signed({4'b0, r1_res});
    assign n_div = {r1_res, 1'b0};
    assign n_a[0] = AX_W'({r1_a0, 1'b0});
    assign n_b[0] = AX_W'({r1_b0, 1'b0});
    assign n_a[1] = AX_W'({r1_a1, 1'b0});
    assign n_b[1] = AX_W'({r1_b1, 1'b0});

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            n_op[4*e+0] = '{num: n_a[e], den: n_b[e], off2: n_ym, near2: n_xm, div: n_div};
            n_op[4*e+1] = '{num: n_a[e], den: n_b[e], off2: n_yp, near2: n_xm, div: n_div};
            n_op[4*e+2] = '{num: n_b[e], den: n_a[e], off2: n_xm, near2: n_ym, div: n_div};
            n_op[4*e+3] = '{num: n_b[e], den: n_a[e], off2: n_xp, near2: n_ym, div: n_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_action <= r1_action;
        for (int l = 0; l < 8; l++) begin
            r2_op[l] <= n_op[l];
        end
    end

    // Crossing lanes.
    logic signed [CW-1:0] w_cross [0:7];

    for (genvar l = 0; l < 8; l++) begin : g_lane
        erpc_edge #(
            .FRAC_BITS(FRAC_BITS)
        ) u_edge (
            .i_clk   (i_clk),
            .i_op    (r2_op[l]),
            .o_cross (w_cross[l])
        );
    end

    // Hold valid and mode alongside the lanes.
    logic r_dv [0:EDGE_LAT-1];
    logic r_da [0:EDGE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < EDGE_LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r2_valid;
            for (int k = 1; k < EDGE_LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
        r_da[0] <= r2_action;
        for (int k = 1; k < EDGE_LAT; k++) begin
            r_da[k] <= r_da[k-1];
        end
    end

    // Stage C1: classify the crossings and form the triangle products.
    logic            r_c1_valid, r_c1_action;
    logic            r_c1_lt0 [0:1], r_c1_gt [0:1];
    logic            r_c1_ux1 [0:1], r_c1_ux2 [0:1], r_c1_uy1 [0:1], r_c1_uy2 [0:1];
    logic [UW-1:0]   r_c1_x1 [0:1], r_c1_x2 [0:1], r_c1_y1 [0:1], r_c1_y2 [0:1];
    logic [2*UW-1:0] r_c1_p1 [0:1], r_c1_p2 [0:1];
    logic [UW-1:0]   n_cx2 [0:1], n_cy2 [0:1];

    function automatic logic in_unit(input logic signed [CW-1:0] v);
        return !v[CW-1] && (unsigned'(v) <= ONE_C);
    endfunction

    function automatic logic above_one(input logic signed [CW-1:0] v);
        return !v[CW-1] && (unsigned'(v) > ONE_C);
    endfunction

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            n_cx2[e] = ONE_U - w_cross[4*e+1][UW-1:0];
            n_cy2[e] = ONE_U - w_cross[4*e+3][UW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_valid <= 1'b0;
        end else begin
            r_c1_valid <= r_dv[EDGE_LAT-1];
        end
        r_c1_action <= r_da[EDGE_LAT-1];
        for (int e = 0; e < 2; e++) begin
            r_c1_lt0[e] <= w_cross[4*e+0][CW-1] && w_cross[4*e+2][CW-1];
            r_c1_gt[e]  <= above_one(w_cross[4*e+1]) && above_one(w_cross[4*e+3]);
            r_c1_ux1[e] <= in_unit(w_cross[4*e+0]);
            r_c1_ux2[e] <= in_unit(w_cross[4*e+1]);
            r_c1_uy1[e] <= in_unit(w_cross[4*e+2]);
            r_c1_uy2[e] <= in_unit(w_cross[4*e+3]);
            r_c1_x1[e]  <= w_cross[4*e+0][UW-1:0];
            r_c1_x2[e]  <= w_cross[4*e+1][UW-1:0];
            r_c1_y1[e]  <= w_cross[4*e+2][UW-1:0];
            r_c1_y2[e]  <= w_cross[4*e+3][UW-1:0];
            r_c1_p1[e]  <= (2*UW)'(w_cross[4*e+0][UW-1:0]) * (2*UW)'(w_cross[4*e+2][UW-1:0]);
            r_c1_p2[e]  <= (2*UW)'(n_cx2[e]) * (2*UW)'(n_cy2[e]);
        end
    end

    // Stage C2: walk the case chain for each ellipse.
    logic          r_c2_valid, r_c2_action;
    logic [UW-1:0] r_c2_cov [0:1];
    logic          r_c2_fault [0:1];
    logic [UW-1:0] n_cov [0:1];
    logic          n_flt [0:1];
    logic [UW:0]   n_sx [0:1], n_sy [0:1];

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            n_sx[e]  = (UW+1)'(r_c1_x1[e]) + (UW+1)'(r_c1_x2[e]);
            n_sy[e]  = (UW+1)'(r_c1_y1[e]) + (UW+1)'(r_c1_y2[e]);
            n_flt[e] = 1'b0;
            if (r_c1_lt0[e]) begin
                n_cov[e] = '0;
            end else if (r_c1_gt[e]) begin
                n_cov[e] = ONE_U;
            end else if (r_c1_ux1[e] && r_c1_ux2[e]) begin
                n_cov[e] = n_sx[e][UW:1];
            end else if (r_c1_uy1[e] && r_c1_uy2[e]) begin
                n_cov[e] = n_sy[e][UW:1];
            end else if (r_c1_ux1[e] && r_c1_uy1[e]) begin
                n_cov[e] = r_c1_p1[e][2*UW-1:UW];
            end else if (r_c1_ux2[e] && r_c1_uy2[e]) begin
                n_cov[e] = ONE_U - r_c1_p2[e][2*UW-1:UW];
            end else if (r_c1_ux1[e] || r_c1_uy1[e]) begin
                n_cov[e] = '0;
            end else if (r_c1_ux2[e] || r_c1_uy2[e]) begin
                n_cov[e] = ONE_U;
            end else begin
                // no case fits: report it and contribute nothing
                n_cov[e] = '0;
                n_flt[e] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_valid <= 1'b0;
        end else begin
            r_c2_valid <= r_c1_valid;
        end
        r_c2_action <= r_c1_action;
        for (int e = 0; e < 2; e++) begin
            r_c2_cov[e]   <= n_cov[e];
            r_c2_fault[e] <= n_flt[e];
        end
    end

    // Stage C3: ring difference, output register.
    logic signed [UW:0] n_diff;
    logic               r_valid, r_fault;
    logic signed [COV_W-1:0] r_coverage;

    assign n_diff = $signed({1'b0, r_c2_cov[0]})
                  - (r_c2_action ? $signed({1'b0, r_c2_cov[1]}) : $signed((UW+1)'(0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fault <= 1'b0;
        end else begin
            r_valid <= r_c2_valid;
            r_fault <= r_c2_valid && (r_c2_fault[0] || (r_c2_action && r_c2_fault[1]));
        end
        r_coverage <= COV_W'(n_diff);
    end

    assign o_valid    = r_valid;
    assign o_fault    = r_fault;
    assign o_coverage = r_coverage;

    // Every accepted transaction surfaces after the fixed latency.
    `ERPC_ASSERT_DLY(a_latency, i_start && !o_busy, LATENCY, o_valid,
        "accepted transaction did not produce a result in time")
    // Fault only travels with a result.
    `ERPC_ASSERT_IMP(a_fault_valid, o_fault, o_valid, "fault without result strobe")
    // An ellipse that matched no case contributes zero.
    `ERPC_ASSERT_IMP(a_fault_zero, r_c2_valid && r_c2_fault[0], r_c2_cov[0] == '0,
        "faulty ellipse carries nonzero coverage")

endmodule

`default_nettype wire

### src/erpc_edge.sv
// ----------------------------------------------------------------------------
// erpc_edge
// Pipelined crossing of one pixel edge with an ellipse, in pixel units.
// ----------------------------------------------------------------------------
`default_nettype none

module erpc_edge
    import erpc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  t_edge_in                    i_op,
    output logic signed [FRAC_BITS+2:0] o_cross
);

    localparam int CW   = FRAC_BITS + 3;
    localparam int P_W  = AX_W + SQ_BITS;
    localparam int SD_W = AX_W + DIV1_QBITS;
    localparam int Q2   = FRAC_BITS + 1;
    localparam int DW2  = N_W + FRAC_BITS;
    localparam int SQW  = 2 * (OFF_W - 1);

    // square the axis and the offset
    logic [OFF_W-2:0]    n_off_abs;
    logic [2*AX_W-1:0]   r_den2;
    logic [SQW-1:0]      r_off2sq;
    t_carry              r_e0_c;

    assign n_off_abs = i_op.off2[OFF_W-1] ? (OFF_W-1)'(-i_op.off2)
                                          : (OFF_W-1)'(i_op.off2);

    always_ff @(posedge i_clk) begin
        r_den2   <= (2*AX_W)'(i_op.den) * (2*AX_W)'(i_op.den);
        r_off2sq <= SQW'(n_off_abs) * SQW'(n_off_abs);
        r_e0_c   <= '{num: i_op.num, den: i_op.den, near2: i_op.near2,
                      div: i_op.div, neg: 1'b0};
    end

    // radicand and miss flag
    logic [SQW-1:0] n_diff;
    t_carry         n_c0;
    assign n_diff = SQW'(r_den2) - r_off2sq;
    always_comb begin
        n_c0     = r_e0_c;
        n_c0.neg = SQW'(r_den2) < r_off2sq;
    end

    logic [T_W-1:0]     r_rm [0:SQ_BITS];
    logic [SQ_BITS-1:0] r_rt [0:SQ_BITS];
    t_carry             r_sc [0:SQ_BITS];

    always_ff @(posedge i_clk) begin
        r_rm[0] <= n_diff[T_W-1:0];
        r_rt[0] <= '0;
        r_sc[0] <= n_c0;
    end

    // floor square root, one result bit per stage
    for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
        localparam int I = SQ_BITS - 1 - k;
        logic [T_W+1:0] n_trial;
        assign n_trial = ((T_W+2)'(r_rt[k]) << (I + 1)) + ((T_W+2)'(1) << (2 * I));
        always_ff @(posedge i_clk) begin
            r_sc[k+1] <= r_sc[k];
            if ((T_W+2)'(r_rm[k]) >= n_trial) begin
                r_rm[k+1] <= T_W'((T_W+2)'(r_rm[k]) - n_trial);
                r_rt[k+1] <= r_rt[k] | (SQ_BITS'(1) << I);
            end else begin
                r_rm[k+1] <= r_rm[k];
                r_rt[k+1] <= r_rt[k];
            end
        end
    end

    // scale the half chord by the other axis, then divide by this one
    logic [P_W-1:0]        r_d1r [0:DIV1_QBITS];
    logic [DIV1_QBITS-1:0] r_d1q [0:DIV1_QBITS];
    t_carry                r_dc  [0:DIV1_QBITS];

    always_ff @(posedge i_clk) begin
        r_d1r[0] <= P_W'(r_sc[SQ_BITS].num) * P_W'(r_rt[SQ_BITS]);
        r_d1q[0] <= '0;
        r_dc[0]  <= r_sc[SQ_BITS];
    end

    for (genvar k = 0; k < DIV1_QBITS; k++) begin : g_div1
        localparam int I = DIV1_QBITS - 1 - k;
        logic [SD_W-1:0] n_sd;
        logic [SD_W-1:0] n_rm;
        assign n_sd = SD_W'(r_dc[k].den) << I;
        assign n_rm = SD_W'(r_d1r[k]);
        always_ff @(posedge i_clk) begin
            r_dc[k+1] <= r_dc[k];
            if (n_rm >= n_sd) begin
                r_d1r[k+1] <= P_W'(n_rm - n_sd);
                r_d1q[k+1] <= r_d1q[k] | (DIV1_QBITS'(1) << I);
            end else begin
                r_d1r[k+1] <= r_d1r[k];
                r_d1q[k+1] <= r_d1q[k];
            end
        end
    end

    // offset from the near edge; negative or far results need no quotient
    logic signed [OFF_W-1:0] n_n;
    logic                    n_big;
    assign n_n   = $signed({2'b0, r_d1q[DIV1_QBITS]}) - r_dc[DIV1_QBITS].near2;
    assign n_big = n_n[OFF_W-2:0] >= (OFF_W-1)'({r_dc[DIV1_QBITS].div, 1'b0});

    logic [DW2-1:0]   r_d2r   [0:Q2];
    logic [Q2-1:0]    r_d2q   [0:Q2];
    logic [DIV_W-1:0] r_d2d   [0:Q2];
    logic             r_d2neg [0:Q2];
    logic             r_d2big [0:Q2];

    always_ff @(posedge i_clk) begin
        r_d2r[0]   <= DW2'(n_n[N_W-1:0]) << FRAC_BITS;
        r_d2q[0]   <= '0;
        r_d2d[0]   <= r_dc[DIV1_QBITS].div;
        r_d2neg[0] <= r_dc[DIV1_QBITS].neg | n_n[OFF_W-1];
        r_d2big[0] <= n_big;
    end

    for (genvar k = 0; k < Q2; k++) begin : g_div2
        localparam int I = Q2 - 1 - k;
        logic [DW2-1:0] n_sd;
        assign n_sd = DW2'(r_d2d[k]) << I;
        always_ff @(posedge i_clk) begin
            r_d2d[k+1]   <= r_d2d[k];
            r_d2neg[k+1] <= r_d2neg[k];
            r_d2big[k+1] <= r_d2big[k];
            if (r_d2r[k] >= n_sd) begin
                r_d2r[k+1] <= r_d2r[k] - n_sd;
                r_d2q[k+1] <= r_d2q[k] | (Q2'(1) << I);
            end else begin
                r_d2r[k+1] <= r_d2r[k];
                r_d2q[k+1] <= r_d2q[k];
            end
        end
    end

    // negative maps to all ones, beyond two pixels to 2.0; both only steer the cases
    logic signed [CW-1:0] r_cross;
    always_ff @(posedge i_clk) begin
        if (r_d2neg[Q2]) begin
            r_cross <= '1;
        end else if (r_d2big[Q2]) begin
            r_cross <= signed'(CW'(1) << (FRAC_BITS + 1));
        end else begin
            r_cross <= signed'(CW'(r_d2q[Q2]));
        end
    end

    assign o_cross = r_cross;

endmodule

`default_nettype wire
